// ===== rtl/phkc_pkg.sv =====
// Package with shared constants and types of the pinned hash-keyed cache.
package phkc_pkg;

	// Default number of slots in the table.
	localparam int ENTRIES_DEF = 32;

	// Field widths fixed by the item format.
	localparam int KEY_W    = 256;
	localparam int WORD_W   = 64;
	localparam int LANE_W   = 2;
	localparam int HANDLE_W = 32;
	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 5;

	// Operation codes carried in the kind field.
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PUT    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PIN    = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic compare;
		logic select;
		logic act;
	} phkc_cmd_t;

endpackage

// ===== rtl/phkc_first.sv =====
// Priority encoder that finds the lowest set bit of a slot vector.
module phkc_first #(
	parameter int N  = phkc_pkg::ENTRIES_DEF,
	parameter int IW = $clog2(N)
) (
	input  logic [N-1:0]  vec,
	output logic          hit,
	output logic [IW-1:0] idx
);

	// Scan from the top so that the lowest set bit wins.
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (vec[i]) begin
				hit = 1'b1;
				idx = IW'(i);
			end
		end
	end

endmodule

// ===== rtl/phkc_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
module phkc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output phkc_pkg::phkc_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CMP  = 3'd1;
	localparam logic [2:0] S_SEL  = 3'd2;
	localparam logic [2:0] S_ACT  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state: a fixed walk from compare to the result cycle.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_CMP;
			end
			S_CMP:  state_d = S_SEL;
			S_SEL:  state_d = S_ACT;
			S_ACT:  state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands and handshake outputs decoded from the state.
	always_comb begin
		cmd.load    = (state_q == S_IDLE) && start;
		cmd.compare = (state_q == S_CMP);
		cmd.select  = (state_q == S_SEL);
		cmd.act     = (state_q == S_ACT);
		busy        = (state_q != S_IDLE);
		done        = (state_q == S_DONE);
	end

endmodule

// ===== rtl/phkc_datapath.sv =====
// Datapath with the key compare array, slot metadata memory and result registers.
module phkc_datapath #(
	parameter int ENTRIES = phkc_pkg::ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  phkc_pkg::phkc_cmd_t                 cmd,
	input  logic [phkc_pkg::KIND_W-1:0]         kind,
	input  logic [phkc_pkg::WORD_W-1:0]         key_word0,
	input  logic [phkc_pkg::WORD_W-1:0]         key_word1,
	input  logic [phkc_pkg::WORD_W-1:0]         key_word2,
	input  logic [phkc_pkg::WORD_W-1:0]         key_word3,
	input  logic [phkc_pkg::WORD_W-1:0]         tag_word,
	input  logic [phkc_pkg::LANE_W-1:0]         lane_in,
	input  logic [phkc_pkg::HANDLE_W-1:0]       handle_in,
	input  logic                                pin_request,
	output logic                                success,
	output logic [phkc_pkg::SLOT_W-1:0]         slot_used,
	output logic [phkc_pkg::LANE_W-1:0]         found_lane,
	output logic [phkc_pkg::HANDLE_W-1:0]       handle_out,
	output logic [phkc_pkg::WORD_W-1:0]         tag_out,
	output logic                                pinned_out
);

	localparam int IW     = $clog2(ENTRIES);
	localparam int KEY_W  = phkc_pkg::KEY_W;
	localparam int META_W = phkc_pkg::WORD_W + phkc_pkg::LANE_W + phkc_pkg::HANDLE_W;

	// Captured item.
	logic [phkc_pkg::KIND_W-1:0]   kind_q;
	logic [KEY_W-1:0]              op_key_q;
	logic [phkc_pkg::WORD_W-1:0]   tag_in_q;
	logic [phkc_pkg::LANE_W-1:0]   lane_in_q;
	logic [phkc_pkg::HANDLE_W-1:0] handle_in_q;
	logic                          pin_req_q;

	// Per-slot cells: key, handle-nonzero flag, valid bit and pin mark.
	logic [KEY_W-1:0]   slot_key_q [ENTRIES];
	logic [ENTRIES-1:0] slot_hnz_q;
	logic [ENTRIES-1:0] slot_valid_q;
	logic [ENTRIES-1:0] pin_q;

	// Slot metadata memory: tag, lane and handle.
	logic [META_W-1:0] meta_mem [ENTRIES];
	logic [META_W-1:0] meta_rd_q;

	// Compare and select stage registers.
	logic [ENTRIES-1:0] match_vec;
	logic [ENTRIES-1:0] live_vec;
	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] match_vec_q;
	logic [ENTRIES-1:0] live_vec_q;
	logic [ENTRIES-1:0] free_vec_q;
	logic               put_hit;
	logic               live_hit;
	logic               free_hit;
	logic [IW-1:0]      put_idx;
	logic [IW-1:0]      live_idx;
	logic [IW-1:0]      free_idx;
	logic               put_hit_q;
	logic               live_hit_q;
	logic               free_hit_q;
	logic [IW-1:0]      put_idx_q;
	logic [IW-1:0]      live_idx_q;
	logic [IW-1:0]      free_idx_q;

	// Action decode.
	logic          act_write;
	logic          act_read;
	logic          act_pin_set;
	logic          act_pin_val;
	logic          act_success;
	logic          act_pinned;
	logic [IW-1:0] act_idx;

	// Result registers.
	logic          res_success_q;
	logic [IW-1:0] res_idx_q;
	logic          res_pinned_q;
	logic          res_meta_q;

	// Capture the item at accept.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q      <= kind;
			op_key_q    <= {key_word3, key_word2, key_word1, key_word0};
			tag_in_q    <= tag_word;
			lane_in_q   <= lane_in;
			handle_in_q <= handle_in;
			pin_req_q   <= pin_request;
		end
	end

	// Parallel key compare and empty test; a slot never written reads as all zero.
	always_comb begin
		logic [KEY_W-1:0] key_eff;
		logic             empty;
		for (int i = 0; i < ENTRIES; i++) begin
			key_eff      = slot_valid_q[i] ? slot_key_q[i] : '0;
			empty        = (key_eff[7:0] == 8'd0) && (key_eff[KEY_W-1 -: 8] == 8'd0)
			               && !(slot_valid_q[i] && slot_hnz_q[i]);
			match_vec[i] = (key_eff == op_key_q);
			live_vec[i]  = match_vec[i] && !empty;
			free_vec[i]  = empty || !pin_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			match_vec_q <= match_vec;
			live_vec_q  <= live_vec;
			free_vec_q  <= free_vec;
		end
	end

	// First-slot search over the registered vectors.
	phkc_first #(.N(ENTRIES), .IW(IW)) u_first_put (
		.vec(match_vec_q), .hit(put_hit), .idx(put_idx)
	);
	phkc_first #(.N(ENTRIES), .IW(IW)) u_first_live (
		.vec(live_vec_q), .hit(live_hit), .idx(live_idx)
	);
	phkc_first #(.N(ENTRIES), .IW(IW)) u_first_free (
		.vec(free_vec_q), .hit(free_hit), .idx(free_idx)
	);

	always_ff @(posedge clk) begin
		if (cmd.select) begin
			put_hit_q  <= put_hit;
			live_hit_q <= live_hit;
			free_hit_q <= free_hit;
			put_idx_q  <= put_idx;
			live_idx_q <= live_idx;
			free_idx_q <= free_idx;
		end
	end

	// Decide what the operation does to the table and what it reports.
	always_comb begin
		act_write   = 1'b0;
		act_read    = 1'b0;
		act_pin_set = 1'b0;
		act_pin_val = 1'b0;
		act_success = 1'b0;
		act_pinned  = 1'b0;
		act_idx     = '0;
		case (kind_q)
			phkc_pkg::KIND_LOOKUP: begin
				if (live_hit_q) begin
					act_idx     = live_idx_q;
					act_read    = 1'b1;
					act_success = 1'b1;
					act_pinned  = pin_q[live_idx_q];
				end
			end
			phkc_pkg::KIND_PUT: begin
				if (put_hit_q) begin
					act_idx     = put_idx_q;
					act_write   = 1'b1;
					act_pin_set = 1'b1;
					act_pin_val = pin_q[put_idx_q] | pin_req_q;
					act_success = 1'b1;
					act_pinned  = pin_q[put_idx_q] | pin_req_q;
				end else if (free_hit_q) begin
					act_idx     = free_idx_q;
					act_write   = 1'b1;
					act_pin_set = 1'b1;
					act_pin_val = pin_req_q;
					act_success = 1'b1;
					act_pinned  = pin_req_q;
				end
			end
			phkc_pkg::KIND_PIN: begin
				if (live_hit_q) begin
					act_idx     = live_idx_q;
					act_pin_set = 1'b1;
					act_pin_val = 1'b1;
					act_success = 1'b1;
					act_pinned  = 1'b1;
				end
			end
			default: begin
				act_success = 1'b0;
			end
		endcase
	end

	// Control bits of the slots: valid and pin marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			pin_q        <= '0;
		end else if (cmd.act) begin
			if (act_write) slot_valid_q[act_idx] <= 1'b1;
			if (act_pin_set) pin_q[act_idx] <= act_pin_val;
		end
	end

	// Key and handle-nonzero cells of the slot written.
	always_ff @(posedge clk) begin
		if (cmd.act && act_write) begin
			slot_key_q[act_idx] <= op_key_q;
			slot_hnz_q[act_idx] <= (handle_in_q != '0);
		end
	end

	// Metadata memory with one port and registered read data.
	always_ff @(posedge clk) begin
		if (cmd.act && act_write) begin
			meta_mem[act_idx] <= {tag_in_q, lane_in_q, handle_in_q};
		end
		if (cmd.act && act_read) begin
			meta_rd_q <= meta_mem[act_idx];
		end
	end

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_success_q <= 1'b0;
			res_idx_q     <= '0;
			res_pinned_q  <= 1'b0;
			res_meta_q    <= 1'b0;
		end else if (cmd.act) begin
			res_success_q <= act_success;
			res_idx_q     <= act_idx;
			res_pinned_q  <= act_pinned;
			res_meta_q    <= act_read;
		end
	end

	// Result fields; metadata shows only on a lookup hit.
	assign success    = res_success_q;
	assign slot_used  = phkc_pkg::SLOT_W'(res_idx_q);
	assign pinned_out = res_pinned_q;
	assign handle_out = res_meta_q ? meta_rd_q[phkc_pkg::HANDLE_W-1:0] : '0;
	assign found_lane = res_meta_q
	                    ? meta_rd_q[phkc_pkg::HANDLE_W +: phkc_pkg::LANE_W] : '0;
	assign tag_out    = res_meta_q
	                    ? meta_rd_q[META_W-1 -: phkc_pkg::WORD_W] : '0;

endmodule

// ===== rtl/pinned_hash_keyed_cache.sv =====
// Top level of the pinned hash-keyed cache: controller plus datapath.
//
//   channel   handshake          payload
//   item in   start, busy        kind, key_word0..3, tag_word, lane_in, handle_in, pin_request
//   result    done (one cycle)   success, slot_used, found_lane, handle_out, tag_out, pinned_out
//
// Between one accept and the next, an item steps in order through a compare against every
// slot key, a first-slot search, one access to the metadata memory, the result
// state in which done is high, and the idle state with busy low.
// No new item is taken while busy is high.
// Reset clears the valid bits and pin marks at once; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module pinned_hash_keyed_cache #(
	parameter int ENTRIES = phkc_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          done,
	input  logic [phkc_pkg::KIND_W-1:0]   kind,
	input  logic [phkc_pkg::WORD_W-1:0]   key_word0,
	input  logic [phkc_pkg::WORD_W-1:0]   key_word1,
	input  logic [phkc_pkg::WORD_W-1:0]   key_word2,
	input  logic [phkc_pkg::WORD_W-1:0]   key_word3,
	input  logic [phkc_pkg::WORD_W-1:0]   tag_word,
	input  logic [phkc_pkg::LANE_W-1:0]   lane_in,
	input  logic [phkc_pkg::HANDLE_W-1:0] handle_in,
	input  logic                          pin_request,
	output logic                          success,
	output logic [phkc_pkg::SLOT_W-1:0]   slot_used,
	output logic [phkc_pkg::LANE_W-1:0]   found_lane,
	output logic [phkc_pkg::HANDLE_W-1:0] handle_out,
	output logic [phkc_pkg::WORD_W-1:0]   tag_out,
	output logic                          pinned_out
);

	phkc_pkg::phkc_cmd_t cmd;

	// Sequencer.
	phkc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Table storage and result forming.
	phkc_datapath #(.ENTRIES(ENTRIES)) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (kind),
		.key_word0   (key_word0),
		.key_word1   (key_word1),
		.key_word2   (key_word2),
		.key_word3   (key_word3),
		.tag_word    (tag_word),
		.lane_in     (lane_in),
		.handle_in   (handle_in),
		.pin_request (pin_request),
		.success     (success),
		.slot_used   (slot_used),
		.found_lane  (found_lane),
		.handle_out  (handle_out),
		.tag_out     (tag_out),
		.pinned_out  (pinned_out)
	);

endmodule

// ===== rtl/phkc_checker.sv =====
// Port-level checker of the pinned hash-keyed cache, bound to the top level.
module phkc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic                          success,
	input logic [phkc_pkg::SLOT_W-1:0]   slot_used,
	input logic [phkc_pkg::LANE_W-1:0]   found_lane,
	input logic [phkc_pkg::HANDLE_W-1:0] handle_out,
	input logic [phkc_pkg::WORD_W-1:0]   tag_out,
	input logic                          pinned_out
);

	// An accepted item makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// The result follows the start of the work by a fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> ##3 done)
		else $error("result not delivered at the expected cycle");

	// A result is shown only while the item is still in work, and for one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !done)
		else $error("result strobe outside an item or longer than one cycle");

	// A failed operation reports all fields as zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !success |-> slot_used == '0 && found_lane == '0 && handle_out == '0
		                     && tag_out == '0 && !pinned_out)
		else $error("failed result carries nonzero fields");

endmodule

bind pinned_hash_keyed_cache phkc_checker u_phkc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.success    (success),
	.slot_used  (slot_used),
	.found_lane (found_lane),
	.handle_out (handle_out),
	.tag_out    (tag_out),
	.pinned_out (pinned_out)
);
